// File: src/fmprc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match rule classifier package
// Shared types, opcodes and the per-rule match function.
// ----------------------------------------------------------------------------
package fmprc_pkg;

  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_INSERT   = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Bit positions in a rule's match mask.
  localparam int MB_DEV   = 0;
  localparam int MB_PROTO = 1;
  localparam int MB_SADDR = 2;
  localparam int MB_DADDR = 3;
  localparam int MB_SPORT = 4;
  localparam int MB_DPORT = 5;

  localparam logic [5:0] ADDR_BITS = 6'd32;

  typedef struct packed {
    logic [7:0]  dev_id;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } pkt_t;

  typedef struct packed {
    logic [5:0]  mask;
    logic [7:0]  dev_id;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  src_len;
    logic [5:0]  dst_len;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } rule_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] rule_index;
    logic       status;
  } res_t;

  // Compare the top len bits of two addresses; zero length matches anything
  // and lengths beyond the address width act as the full width.
  function automatic logic prefix_match(input logic [31:0] a, input logic [31:0] b,
                                        input logic [5:0] len);
    logic [5:0]  l;
    logic [31:0] m;
    l = (len > ADDR_BITS) ? ADDR_BITS : len;
    m = 32'hFFFF_FFFF << (ADDR_BITS - l);
    return (len == 6'd0) || (((a ^ b) & m) == 32'h0);
  endfunction

  function automatic logic rule_match(input rule_t r, input pkt_t p);
    logic ok;
    ok = 1'b1;
    if (r.mask[MB_DEV] && (r.dev_id != p.dev_id)) ok = 1'b0;
    if (r.mask[MB_PROTO] && (r.proto != p.proto)) ok = 1'b0;
    if (r.mask[MB_SADDR] && !prefix_match(r.src_addr, p.src_addr, r.src_len)) ok = 1'b0;
    if (r.mask[MB_DADDR] && !prefix_match(r.dst_addr, p.dst_addr, r.dst_len)) ok = 1'b0;
    if (r.mask[MB_SPORT] && (r.src_port != p.src_port)) ok = 1'b0;
    if (r.mask[MB_DPORT] && (r.dst_port != p.dst_port)) ok = 1'b0;
    return ok;
  endfunction

endpackage

// File: src/fmprc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match rule classifier channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fmprc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  dev_id;
  logic [7:0]  proto;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [5:0]  match_mask;
  logic [5:0]  src_prefix_len;
  logic [5:0]  dst_prefix_len;

  modport source (output valid, opcode, dev_id, proto, src_addr, dst_addr, src_port,
                  dst_port, match_mask, src_prefix_len, dst_prefix_len, input ready);
  modport sink (input valid, opcode, dev_id, proto, src_addr, dst_addr, src_port,
                dst_port, match_mask, src_prefix_len, dst_prefix_len, output ready);
endinterface

interface fmprc_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [3:0] rule_index;
  logic       status;

  modport source (output valid, hit, rule_index, status, input ready);
  modport sink (input valid, hit, rule_index, status, output ready);
endinterface

// File: src/fmprc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match rule classifier cell
// Holds one rule, compares the passing packet and forwards it with the
// first-match carry to the next cell.
// ----------------------------------------------------------------------------
module fmprc_cell #(
  parameter int IDX_W   = 4,
  parameter int CELL_ID = 0
) (
  input  logic                clk,
  input  logic                wr_en,
  input  fmprc_pkg::rule_t    wr_rule,
  input  logic                active,
  input  fmprc_pkg::pkt_t     pkt_in,
  input  logic                found_in,
  input  logic [IDX_W-1:0]    idx_in,
  output fmprc_pkg::pkt_t     pkt_out,
  output logic                found_out,
  output logic [IDX_W-1:0]    idx_out
);

  fmprc_pkg::rule_t rule;
  logic             match;

  assign match = active && fmprc_pkg::rule_match(rule, pkt_in);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule <= wr_rule;
    end
  end

  // An earlier match always wins; else a match here claims the packet.
  always_ff @(posedge clk) begin
    pkt_out   <= pkt_in;
    found_out <= found_in || match;
    if (found_in) begin
      idx_out <= idx_in;
    end else if (match) begin
      idx_out <= IDX_W'(CELL_ID);
    end else begin
      idx_out <= '0;
    end
  end

endmodule

// File: src/first_match_packet_rule_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match packet rule classifier
// Ordered rule table held in a chain of compare cells; classify, insert and
// clear requests, one response per request.
// ----------------------------------------------------------------------------
//
//  Port  Dir     Payload                                          Purpose
//  ----  ------  -----------------------------------------------  ----------------
//  req   sink    opcode, dev_id, proto, src/dst_addr, src/dst_port,  requests
//                match_mask, src/dst_prefix_len
//  rsp   source  hit, rule_index, status                          responses
//
// Cycles: a classify transaction walks the packet through all MAX_RULES cells,
// one cell per cycle, and the next request waits until the walk is over. Insert
// and clear complete in the cycle of acceptance, so they may follow one another
// every cycle while the response side keeps up.
// Reset: rst is synchronous and active high; it empties the table (the rule
// count returns to zero) and drops any response not yet delivered.
// Stalls: the response register lets a new request be accepted while the
// previous response waits; a further result waits in a holding register and
// blocks the request side until the response register frees.
// ----------------------------------------------------------------------------
module first_match_packet_rule_classifier #(
  parameter int MAX_RULES = 16
) (
  input  logic            clk,
  input  logic            rst,
  fmprc_req_if.sink       req,
  fmprc_rsp_if.source     rsp
);

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  // Controller state codes.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] walk_cnt;
  logic [CNT_W-1:0] rule_count;

  fmprc_pkg::pkt_t  pkt_q;
  fmprc_pkg::rule_t wr_rule;
  fmprc_pkg::res_t  pend;
  fmprc_pkg::res_t  rsp_res;
  fmprc_pkg::res_t  imm_res;
  fmprc_pkg::res_t  tail_res;
  fmprc_pkg::res_t  res_sel;
  logic             rsp_valid;

  logic             accept;
  logic             out_free;
  logic             ins_ok;
  logic             walk_done;
  logic             imm_done;
  logic             load_out;
  logic             load_pend;
  logic [IDX_W+3:0] tail_wide;
  logic [CNT_W+3:0] count_wide;

  // The chain: cell i reads the output of cell i-1; cell 0 reads pkt_q.
  fmprc_pkg::pkt_t        chain_pkt   [MAX_RULES+1];
  logic [MAX_RULES:0]     chain_found;
  logic [IDX_W-1:0]       chain_idx   [MAX_RULES+1];
  logic [MAX_RULES-1:0]   wr_en;
  logic [MAX_RULES-1:0]   active;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;
  assign ins_ok    = (rule_count < CNT_W'(MAX_RULES));

  assign wr_rule.mask     = req.match_mask;
  assign wr_rule.dev_id   = req.dev_id;
  assign wr_rule.proto    = req.proto;
  assign wr_rule.src_addr = req.src_addr;
  assign wr_rule.dst_addr = req.dst_addr;
  assign wr_rule.src_len  = req.src_prefix_len;
  assign wr_rule.dst_len  = req.dst_prefix_len;
  assign wr_rule.src_port = req.src_port;
  assign wr_rule.dst_port = req.dst_port;

  assign chain_pkt[0]   = pkt_q;
  assign chain_found[0] = 1'b0;
  assign chain_idx[0]   = '0;

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    // Only rules below the count take part; an insert writes the cell at the count.
    assign active[i] = (CNT_W'(i) < rule_count);
    assign wr_en[i]  = accept && (req.opcode == fmprc_pkg::OP_INSERT) && ins_ok &&
                       (rule_count == CNT_W'(i));

    fmprc_cell #(
      .IDX_W   (IDX_W),
      .CELL_ID (i)
    ) u_cell (
      .clk       (clk),
      .wr_en     (wr_en[i]),
      .wr_rule   (wr_rule),
      .active    (active[i]),
      .pkt_in    (chain_pkt[i]),
      .found_in  (chain_found[i]),
      .idx_in    (chain_idx[i]),
      .pkt_out   (chain_pkt[i+1]),
      .found_out (chain_found[i+1]),
      .idx_out   (chain_idx[i+1])
    );
  end

  // The response index is the low four bits of the rule position.
  assign tail_wide  = {4'b0000, chain_idx[MAX_RULES]};
  assign count_wide = {4'b0000, rule_count};

  assign tail_res.hit        = chain_found[MAX_RULES];
  assign tail_res.rule_index = tail_wide[3:0];
  assign tail_res.status     = 1'b0;

  // Insert, clear and the unused opcode answer at once.
  always_comb begin
    imm_res = '0;
    if (req.opcode == fmprc_pkg::OP_INSERT) begin
      if (ins_ok) begin
        imm_res.rule_index = count_wide[3:0];
      end else begin
        imm_res.status = 1'b1;
      end
    end
  end

  assign imm_done  = (state == S_IDLE) && accept && (req.opcode != fmprc_pkg::OP_CLASSIFY);
  assign walk_done = (state == S_WALK) && (walk_cnt == '0);
  assign load_out  = out_free && (imm_done || walk_done || (state == S_HOLD));
  assign load_pend = !out_free && (imm_done || walk_done);

  always_comb begin
    unique case (state)
      S_WALK:  res_sel = tail_res;
      S_HOLD:  res_sel = pend;
      default: res_sel = imm_res;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk_cnt   <= '0;
      rule_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority case (req.opcode)
              fmprc_pkg::OP_CLASSIFY: begin
                state    <= S_WALK;
                walk_cnt <= CNT_W'(MAX_RULES);
              end
              fmprc_pkg::OP_INSERT: begin
                if (ins_ok) begin
                  rule_count <= rule_count + CNT_W'(1);
                end
              end
              fmprc_pkg::OP_CLEAR: begin
                rule_count <= '0;
              end
              default: begin
              end
            endcase
            if (imm_done && !out_free) begin
              state <= S_HOLD;
            end
          end
        end
        S_WALK: begin
          if (walk_cnt == '0) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end else begin
            walk_cnt <= walk_cnt - CNT_W'(1);
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pkt_q.dev_id   <= req.dev_id;
      pkt_q.proto    <= req.proto;
      pkt_q.src_addr <= req.src_addr;
      pkt_q.dst_addr <= req.dst_addr;
      pkt_q.src_port <= req.src_port;
      pkt_q.dst_port <= req.dst_port;
    end
    if (load_pend) begin
      pend <= res_sel;
    end
    if (load_out) begin
      rsp_res <= res_sel;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_res.hit;
  assign rsp.rule_index = rsp_res.rule_index;
  assign rsp.status     = rsp_res.status;

  // A held result only exists while the response register is still occupied.
  a_hold_needs_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> rsp_valid)
    else $error("holding a result while the response register is empty");

  // The table never holds more than MAX_RULES rules.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CNT_W'(MAX_RULES))
    else $error("rule count beyond table size");

  // A successful insert grows the table by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.opcode == fmprc_pkg::OP_INSERT) && ins_ok) |=>
      (rule_count == CNT_W'($past(rule_count) + 1'b1)))
    else $error("insert did not advance the rule count");

  // A classify transaction always starts a walk through the chain.
  a_classify_walks: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.opcode == fmprc_pkg::OP_CLASSIFY)) |=> (state == S_WALK))
    else $error("classify did not start a walk");

endmodule

// File: sim/tb_first_match_packet_rule_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match packet rule classifier testbench
// Drives classify, insert, clear and unused-opcode requests into the rule
// table. A behavioural copy of the table predicts every response, and each
// delivered response is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_first_match_packet_rule_classifier;

  localparam int MAX_RULES = 16;
  // The encoding that the block does not use; it must answer with all zeros.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // A classify walks the packet through all MAX_RULES cells, so this is a
  // comfortable margin for anything still inside the block at the end.
  localparam int SETTLE_CYCLES = 2 * MAX_RULES + 8;

  // One request as the sender sees it.
  typedef struct {
    logic [1:0]      opcode;
    fmprc_pkg::pkt_t pkt;
    logic [5:0]      mask;
    logic [5:0]      src_len;
    logic [5:0]      dst_len;
  } req_item_t;

  logic clk;
  logic rst;

  fmprc_req_if req();
  fmprc_rsp_if rsp();

  first_match_packet_rule_classifier #(
    .MAX_RULES(MAX_RULES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Behavioural copy of the rule table, updated at the moment each request
  // transaction is accepted.
  fmprc_pkg::rule_t acl_table [MAX_RULES];
  int               acl_count;

  // Responses predicted but not yet delivered, oldest first.
  fmprc_pkg::res_t  pending_outcomes [$];

  int    error_count;
  int    sent_items;
  int    req_gap_pct;    // chance per cycle that the sender holds back
  int    rsp_stall_pct;  // chance per cycle that the receiver is not ready
  int    rsp_hold_left;  // cycles of forced back-pressure still to run

  // Clock generation: 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Bits of an address covered by a prefix of the given length. A length of
  // zero covers nothing, so any address matches; anything past 32 is a full
  // 32-bit compare.
  function automatic logic [31:0] prefix_keep(input logic [5:0] len);
    int n;
    if (len == 6'd0) return 32'h0;
    n = (len > 6'd32) ? 32 : int'(len);
    return 32'hFFFF_FFFF << (32 - n);
  endfunction

  function automatic bit rule_covers(input fmprc_pkg::rule_t r, input fmprc_pkg::pkt_t p);
    bit ok;
    ok = 1'b1;
    if (r.mask[fmprc_pkg::MB_DEV])   ok &= (r.dev_id == p.dev_id);
    if (r.mask[fmprc_pkg::MB_PROTO]) ok &= (r.proto == p.proto);
    if (r.mask[fmprc_pkg::MB_SADDR])
      ok &= (((r.src_addr ^ p.src_addr) & prefix_keep(r.src_len)) == 32'h0);
    if (r.mask[fmprc_pkg::MB_DADDR])
      ok &= (((r.dst_addr ^ p.dst_addr) & prefix_keep(r.dst_len)) == 32'h0);
    if (r.mask[fmprc_pkg::MB_SPORT]) ok &= (r.src_port == p.src_port);
    if (r.mask[fmprc_pkg::MB_DPORT]) ok &= (r.dst_port == p.dst_port);
    return ok;
  endfunction

  // Applies one accepted request to the table copy and returns the response
  // that the block must give for it.
  function automatic fmprc_pkg::res_t apply_request(input req_item_t it);
    fmprc_pkg::res_t  outcome;
    fmprc_pkg::rule_t r;
    outcome = '0;
    case (it.opcode)
      fmprc_pkg::OP_CLASSIFY: begin
        for (int i = 0; i < acl_count; i++) begin
          if (rule_covers(acl_table[i], it.pkt)) begin
            outcome.hit        = 1'b1;
            outcome.rule_index = i[3:0];
            break;
          end
        end
      end
      fmprc_pkg::OP_INSERT: begin
        if (acl_count >= MAX_RULES) begin
          outcome.status = 1'b1;
        end else begin
          r.mask     = it.mask;
          r.dev_id   = it.pkt.dev_id;
          r.proto    = it.pkt.proto;
          r.src_addr = it.pkt.src_addr;
          r.dst_addr = it.pkt.dst_addr;
          r.src_len  = it.src_len;
          r.dst_len  = it.dst_len;
          r.src_port = it.pkt.src_port;
          r.dst_port = it.pkt.dst_port;
          acl_table[acl_count] = r;
          outcome.rule_index   = acl_count[3:0];
          acl_count++;
        end
      end
      fmprc_pkg::OP_CLEAR: begin
        acl_count = 0;
      end
      default: begin
        // Unused opcode: the table is left alone and the response is all zeros.
      end
    endcase
    return outcome;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  function automatic req_item_t make_item(input logic [1:0] op, input logic [7:0] dev,
                                          input logic [7:0] pr, input logic [31:0] sa,
                                          input logic [31:0] da, input logic [15:0] sp,
                                          input logic [15:0] dp, input logic [5:0] mask,
                                          input logic [5:0] slen, input logic [5:0] dlen);
    req_item_t it;
    it.opcode       = op;
    it.pkt.dev_id   = dev;
    it.pkt.proto    = pr;
    it.pkt.src_addr = sa;
    it.pkt.dst_addr = da;
    it.pkt.src_port = sp;
    it.pkt.dst_port = dp;
    it.mask         = mask;
    it.src_len      = slen;
    it.dst_len      = dlen;
    return it;
  endfunction

  // Interface and protocol numbers come half the time from a small pool, so
  // that rules and unrelated packets still agree on them now and then.
  function automatic fmprc_pkg::pkt_t random_packet();
    fmprc_pkg::pkt_t p;
    p.dev_id   = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    p.proto    = $urandom_range(1) ? 8'($urandom_range(2) * 11 + 1) : 8'($urandom_range(255));
    p.src_addr = $urandom;
    p.dst_addr = $urandom;
    p.src_port = 16'($urandom_range(65535));
    p.dst_port = 16'($urandom_range(65535));
    return p;
  endfunction

  // Prefix lengths: any-address, exact, clamped lengths past 32, and the
  // ordinary range in between.
  function automatic logic [5:0] random_prefix_len();
    case ($urandom_range(9))
      0:       return 6'd0;
      1:       return 6'd32;
      2:       return 6'($urandom_range(63, 33));
      default: return 6'($urandom_range(31, 1));
    endcase
  endfunction

  function automatic req_item_t random_rule();
    req_item_t it;
    it.opcode  = fmprc_pkg::OP_INSERT;
    it.pkt     = random_packet();
    it.mask    = 6'($urandom_range(63));
    it.src_len = random_prefix_len();
    it.dst_len = random_prefix_len();
    return it;
  endfunction

  // A packet built to satisfy stored rule idx; with spoil set, one checked
  // field is then disturbed inside its compared bits so the rule misses.
  function automatic req_item_t packet_aimed_at(input int idx, input bit spoil);
    req_item_t        it;
    fmprc_pkg::rule_t r;
    logic [31:0]      keep;
    int               pick;
    int               n;
    r = acl_table[idx];
    it.opcode  = fmprc_pkg::OP_CLASSIFY;
    it.pkt     = random_packet();
    it.mask    = 6'($urandom_range(63));
    it.src_len = 6'($urandom_range(63));
    it.dst_len = 6'($urandom_range(63));
    if (r.mask[fmprc_pkg::MB_DEV])   it.pkt.dev_id   = r.dev_id;
    if (r.mask[fmprc_pkg::MB_PROTO]) it.pkt.proto    = r.proto;
    if (r.mask[fmprc_pkg::MB_SPORT]) it.pkt.src_port = r.src_port;
    if (r.mask[fmprc_pkg::MB_DPORT]) it.pkt.dst_port = r.dst_port;
    if (r.mask[fmprc_pkg::MB_SADDR]) begin
      keep = prefix_keep(r.src_len);
      it.pkt.src_addr = (r.src_addr & keep) | (it.pkt.src_addr & ~keep);
    end
    if (r.mask[fmprc_pkg::MB_DADDR]) begin
      keep = prefix_keep(r.dst_len);
      it.pkt.dst_addr = (r.dst_addr & keep) | (it.pkt.dst_addr & ~keep);
    end
    if (spoil && (r.mask != 6'd0)) begin
      do pick = $urandom_range(5); while (!r.mask[pick]);
      case (pick)
        fmprc_pkg::MB_DEV:   it.pkt.dev_id[$urandom_range(7)]    ^= 1'b1;
        fmprc_pkg::MB_PROTO: it.pkt.proto[$urandom_range(7)]     ^= 1'b1;
        fmprc_pkg::MB_SPORT: it.pkt.src_port[$urandom_range(15)] ^= 1'b1;
        fmprc_pkg::MB_DPORT: it.pkt.dst_port[$urandom_range(15)] ^= 1'b1;
        fmprc_pkg::MB_SADDR: begin
          // A zero-length prefix cannot be missed, so nothing to disturb.
          if (r.src_len != 6'd0) begin
            n = (r.src_len > 6'd32) ? 32 : int'(r.src_len);
            it.pkt.src_addr[32 - $urandom_range(n, 1)] ^= 1'b1;
          end
        end
        default: begin
          if (r.dst_len != 6'd0) begin
            n = (r.dst_len > 6'd32) ? 32 : int'(r.dst_len);
            it.pkt.dst_addr[32 - $urandom_range(n, 1)] ^= 1'b1;
          end
        end
      endcase
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request, with random idle cycles before it, and holds it until
  // the block takes it. The prediction is made at the accepting edge. Valid is
  // left high afterwards; the next call or stop_requests decides what follows.
  task automatic send_request(input req_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < req_gap_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid          <= 1'b1;
    req.opcode         <= it.opcode;
    req.dev_id         <= it.pkt.dev_id;
    req.proto          <= it.pkt.proto;
    req.src_addr       <= it.pkt.src_addr;
    req.dst_addr       <= it.pkt.dst_addr;
    req.src_port       <= it.pkt.src_port;
    req.dst_port       <= it.pkt.dst_port;
    req.match_mask     <= it.mask;
    req.src_prefix_len <= it.src_len;
    req.dst_prefix_len <= it.dst_len;
    do @(posedge clk); while (!req.ready);
    pending_outcomes.push_back(apply_request(it));
    sent_items++;
  endtask

  task automatic stop_requests();
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  // Ready is redrawn every falling edge, except during a forced hold-off,
  // which is counted down here one cycle at a time.
  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp.ready     <= 1'b0;
      rsp_hold_left <= rsp_hold_left - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Every delivered response transaction is matched against the oldest
  // outstanding prediction.
  always @(posedge clk) begin : response_check
    fmprc_pkg::res_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("response with nothing outstanding, rule_index",
                        int'(rsp.rule_index), 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp.hit !== want.hit)
          report_mismatch("hit", int'(rsp.hit), int'(want.hit));
        if (rsp.rule_index !== want.rule_index)
          report_mismatch("rule_index", int'(rsp.rule_index), int'(want.rule_index));
        if (rsp.status !== want.status)
          report_mismatch("status", int'(rsp.status), int'(want.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // An empty table misses everything, and the unused opcode changes nothing.
  task automatic test_empty_table_and_unused_opcode();
    send_request(make_item(fmprc_pkg::OP_CLASSIFY, 8'hFF, 8'hFF, '1, '1, 16'hFFFF,
                           16'hFFFF, 6'h3F, 6'h3F, 6'h3F));
    send_request(make_item(OP_UNUSED, 8'hFF, 8'hFF, '1, '1, 16'hFFFF, 16'hFFFF,
                           6'h3F, 6'h3F, 6'h3F));
  endtask

  // A handful of hand-built rules, each of which the next packet must hit
  // first, including a single-bit miss at a clamped full-length prefix.
  task automatic test_first_match_fields();
    send_request(make_item(fmprc_pkg::OP_INSERT, 8'hFF, 8'hFF, '1, '1, 16'hFFFF,
                           16'hFFFF, 6'h3F, 6'h3F, 6'h3F));
    send_request(make_item(fmprc_pkg::OP_CLASSIFY, 8'hFF, 8'hFF, '1, '1, 16'hFFFF,
                           16'hFFFF, 6'h00, 6'h00, 6'h00));
    send_request(make_item(fmprc_pkg::OP_CLASSIFY, 8'hFF, 8'hFF, 32'hFFFF_FFFE, '1,
                           16'hFFFF, 16'hFFFF, 6'h00, 6'h00, 6'h00));
    // Source /16 with the destination compare enabled but zero length.
    send_request(make_item(fmprc_pkg::OP_INSERT, 8'h12, 8'h34, 32'hC0A8_0000, 32'h0,
                           16'h1234, 16'h5678,
                           (6'd1 << fmprc_pkg::MB_SADDR) | (6'd1 << fmprc_pkg::MB_DADDR),
                           6'd16, 6'd0));
    send_request(make_item(fmprc_pkg::OP_CLASSIFY, 8'h00, 8'h00, 32'hC0A8_FFFF,
                           32'h8765_4321, 16'h0, 16'h0, 6'h00, 6'h00, 6'h00));
    send_request(make_item(fmprc_pkg::OP_INSERT, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0,
                           16'h0, 6'h3F, 6'd32, 6'd32));
    send_request(make_item(fmprc_pkg::OP_CLASSIFY, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0,
                           16'h0, 6'h00, 6'h00, 6'h00));
    send_request(make_item(fmprc_pkg::OP_INSERT, 8'd6, 8'd17, 32'hDEAD_BEEF,
                           32'h0BAD_F00D, 16'd53, 16'd53,
                           (6'd1 << fmprc_pkg::MB_DEV) | (6'd1 << fmprc_pkg::MB_PROTO) |
                           (6'd1 << fmprc_pkg::MB_SPORT) | (6'd1 << fmprc_pkg::MB_DPORT),
                           6'd33, 6'd33));
    send_request(make_item(fmprc_pkg::OP_CLASSIFY, 8'd6, 8'd17, 32'h0A00_0001,
                           32'h0A00_0002, 16'd53, 16'd53, 6'h00, 6'h00, 6'h00));
  endtask

  // Fills the table, ending with a catch-all rule in the last slot, then
  // checks the refused insert, a classify against the full table and clear.
  task automatic test_full_table();
    while (acl_count < MAX_RULES - 1)
      send_request(random_rule());
    send_request(make_item(fmprc_pkg::OP_INSERT, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0,
                           16'h0, 6'h00, 6'h00, 6'h00));
    send_request(random_rule());
    send_request(make_item(fmprc_pkg::OP_CLASSIFY, 8'hA5, 8'h5A, 32'h5555_AAAA,
                           32'hAAAA_5555, 16'h00FF, 16'hFF00, 6'h00, 6'h00, 6'h00));
    send_request(make_item(fmprc_pkg::OP_CLEAR, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0,
                           16'h0, 6'h00, 6'h00, 6'h00));
    send_request(make_item(fmprc_pkg::OP_CLASSIFY, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0,
                           16'h0, 6'h00, 6'h00, 6'h00));
  endtask

  // One random request of any kind, with every field unconstrained.
  function automatic req_item_t random_noise();
    req_item_t it;
    it.opcode       = 2'($urandom_range(3));
    it.pkt          = random_packet();
    it.pkt.dev_id   = 8'($urandom_range(255));
    it.pkt.proto    = 8'($urandom_range(255));
    it.mask         = 6'($urandom_range(63));
    it.src_len      = 6'($urandom_range(63));
    it.dst_len      = 6'($urandom_range(63));
    return it;
  endfunction

  // A typical session: usually clear, build a few rules, then classify
  // packets aimed at those rules (hitting or just missing) or at nothing in
  // particular. Occasionally the table is overfilled or the session is just
  // noise.
  task automatic run_session();
    int        n_rules;
    int        n_lookups;
    req_item_t probe;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(6, 1)) send_request(random_noise());
    end else begin
      if ($urandom_range(99) < 80)
        send_request(make_item(fmprc_pkg::OP_CLEAR, 8'($urandom_range(255)),
                               8'($urandom_range(255)), $urandom, $urandom,
                               16'($urandom_range(65535)), 16'($urandom_range(65535)),
                               6'($urandom_range(63)), 6'($urandom_range(63)),
                               6'($urandom_range(63))));
      n_rules   = ($urandom_range(99) < 15) ? $urandom_range(20, 12) : $urandom_range(6, 1);
      n_lookups = $urandom_range(8, 2);
      repeat (n_rules) send_request(random_rule());
      repeat (n_lookups) begin
        if ((acl_count > 0) && ($urandom_range(99) < 70)) begin
          send_request(packet_aimed_at($urandom_range(acl_count - 1),
                                       $urandom_range(99) < 35));
        end else begin
          probe        = random_noise();
          probe.opcode = fmprc_pkg::OP_CLASSIFY;
          send_request(probe);
        end
      end
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int start;
    start = sent_items;
    while (sent_items - start < n_items)
      run_session();
  endtask

  // The receiver refuses responses for a long stretch while the sender keeps
  // offering back-to-back inserts, clears and random requests, so the response
  // register and the holding register fill and the request side must stall.
  task automatic test_output_backpressure();
    int saved_gap;
    int saved_stall;
    saved_gap     = req_gap_pct;
    saved_stall   = rsp_stall_pct;
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    stop_requests();
    @(posedge clk);
    rsp_hold_left = 250;
    send_request(make_item(fmprc_pkg::OP_CLEAR, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0,
                           16'h0, 6'h00, 6'h00, 6'h00));
    repeat (40) begin
      case ($urandom_range(9))
        0:       send_request(make_item(fmprc_pkg::OP_CLEAR, 8'h00, 8'h00, 32'h0, 32'h0,
                                        16'h0, 16'h0, 6'h00, 6'h00, 6'h00));
        1:       send_request(random_noise());
        default: send_request(random_rule());
      endcase
    end
    req_gap_pct   = saved_gap;
    rsp_stall_pct = saved_stall;
  endtask

  // --------------------------------------------------------------------------
  // Run sequence and end of test
  // --------------------------------------------------------------------------

  initial begin
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.opcode         = fmprc_pkg::OP_CLASSIFY;
    req.dev_id         = '0;
    req.proto          = '0;
    req.src_addr       = '0;
    req.dst_addr       = '0;
    req.src_port       = '0;
    req.dst_port       = '0;
    req.match_mask     = '0;
    req.src_prefix_len = '0;
    req.dst_prefix_len = '0;
    rsp.ready          = 1'b0;
    acl_count          = 0;
    error_count        = 0;
    sent_items         = 0;
    rsp_hold_left      = 0;
    req_gap_pct        = 10;
    rsp_stall_pct      = 57;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, under the first idling pattern.
    test_empty_table_and_unused_opcode();
    test_first_match_fields();
    test_full_table();
    test_output_backpressure();

    // Random part: sender rarely idle and receiver often stalled, then the
    // reverse, then full throughput on both sides.
    test_random_traffic(560);
    req_gap_pct   = 57;
    rsp_stall_pct = 10;
    test_random_traffic(560);
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    test_random_traffic(560);

    stop_requests();
    while (pending_outcomes.size() != 0)
      @(posedge clk);
    // Anything that turns up now has no prediction and is reported.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run (about 10 ms of a 1 ms run).
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: first_match_packet_rule_classifier.f
src/fmprc_pkg.sv
src/fmprc_if.sv
src/fmprc_cell.sv
src/first_match_packet_rule_classifier.sv
sim/tb_first_match_packet_rule_classifier.sv
